// File: hw/rtl/tvd_pkg.sv
// Shared types and constants for the slope limiter.
package tvd_pkg;

   localparam int unsigned MAG_W = 32;
   localparam int unsigned SLOPE_W = 33;
   localparam int unsigned QDEPTH = 2;

   typedef enum logic [1:0] {
      MODE_SUPERBEE = 2'd0,
      MODE_MINBEE   = 2'd1,
      MODE_VANLEER  = 2'd2,
      MODE_VANALBADA = 2'd3
   } mode_type;

   // one classified window: magnitudes of the differences and flags
   typedef struct packed {
      logic [MAG_W-1:0] bmag;
      logic [MAG_W-1:0] fmag;
      logic             neg;
      logic             zero;
   } job_type;

endpackage

// File: hw/rtl/tvd_front.sv
// Front end: holds the cell window and classifies each full window.
module tvd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [31:0]       cell_value,
   input  logic              row_start,
   output logic              push,
   output tvd_pkg::job_type  job,
   input  logic              q_full
);
   logic [31:0] w0_ff, w0_in, w1_ff, w1_in;
   logic [1:0]  fill_ff, fill_in, fill_eff;
   logic        accept;
   logic [32:0] bd, fd, bneg, fneg;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign fill_eff = row_start ? 2'd0 : fill_ff;
   assign push     = accept && (fill_eff == 2'd2);

   always_comb begin
      bd   = {w1_ff[31], w1_ff} - {w0_ff[31], w0_ff};
      fd   = {cell_value[31], cell_value} - {w1_ff[31], w1_ff};
      bneg = 33'd0 - bd;
      fneg = 33'd0 - fd;
      job.bmag = bd[32] ? bneg[31:0] : bd[31:0];
      job.fmag = fd[32] ? fneg[31:0] : fd[31:0];
      job.neg  = bd[32];
      job.zero = (bd == 33'd0) || (fd == 33'd0) || (bd[32] != fd[32]);
   end

   always_comb begin
      w0_in   = w0_ff;
      w1_in   = w1_ff;
      fill_in = fill_ff;
      if (accept) begin
         w0_in   = w1_ff;
         w1_in   = cell_value;
         fill_in = (fill_eff == 2'd2) ? 2'd2 : fill_eff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w0_ff   <= '0;
         w1_ff   <= '0;
         fill_ff <= '0;
      end else begin
         w0_ff   <= w0_in;
         w1_ff   <= w1_in;
         fill_ff <= fill_in;
      end
   end
endmodule

// File: hw/rtl/tvd_fifo.sv
// Two-entry job queue between front and back.
module tvd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tvd_pkg::job_type  wdata,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output tvd_pkg::job_type  rdata
);
   tvd_pkg::job_type mem_ff [tvd_pkg::QDEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'(tvd_pkg::QDEPTH));
   assign empty = (cnt_ff == 2'd0);
   assign rdata = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// File: hw/rtl/tvd_back.sv
// Back end: limiter arithmetic with a shared multiplier and radix-2 divider.
module tvd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  tvd_pkg::mode_type           mode,
   input  logic                        q_empty,
   input  tvd_pkg::job_type            job,
   output logic                        pop,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [tvd_pkg::SLOPE_W-1:0] out_slope
);
   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_SQB  = 8'b0000_0010,
      ST_SQF  = 8'b0000_0100,
      ST_ML0  = 8'b0000_1000,
      ST_ML1  = 8'b0001_0000,
      ST_PREP = 8'b0010_0000,
      ST_DIV  = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   state_type   st_ff, st_in;
   logic [31:0] b_ff, f_ff, mag_ff, mag_in, nlo_ff, nlo_in;
   logic        neg_ff;
   logic [63:0] bsq_ff, fsq_ff;
   logic [64:0] p0_ff, p1_ff, rem_ff, rem_in, den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        ov_ff, ov_in;
   logic [32:0] osl_ff, osl_in, ssum, mag_neg;
   logic [32:0] ma, mb;
   logic [65:0] prod, trial, tsub;
   logic [96:0] num, num_sel;
   logic        le, le2, use_div;
   logic [31:0] direct;

   assign ssum = {1'b0, b_ff} + {1'b0, f_ff};
   assign pop  = (st_ff == ST_IDLE) && !q_empty;
   assign out_valid = ov_ff;
   assign out_slope = osl_ff;

   always_comb begin
      unique case (st_ff)
         ST_SQB:  begin ma = {1'b0, b_ff}; mb = {1'b0, b_ff}; end
         ST_SQF:  begin ma = {1'b0, f_ff}; mb = {1'b0, f_ff}; end
         ST_ML0:  begin ma = {1'b0, bsq_ff[31:0]}; mb = ssum; end
         ST_ML1:  begin ma = {1'b0, bsq_ff[63:32]}; mb = ssum; end
         default: begin ma = '0; mb = '0; end
      endcase
      prod = ma * mb;
   end

   always_comb begin
      le  = (b_ff <= f_ff);
      le2 = ({b_ff, 1'b0} <= {1'b0, f_ff});
      num = {p1_ff, 32'd0} + {32'd0, p0_ff};
      num_sel = '0;
      den_in  = den_ff;
      use_div = 1'b0;
      direct  = le ? b_ff : f_ff;
      case (mode)
         tvd_pkg::MODE_SUPERBEE: begin
            use_div = le2;
            num_sel = {32'd0, bsq_ff, 1'b0};
            den_in  = {33'd0, f_ff};
         end
         tvd_pkg::MODE_MINBEE: begin
            use_div = le2;
            num_sel = {33'd0, bsq_ff};
            den_in  = {33'd0, f_ff};
         end
         tvd_pkg::MODE_VANLEER: begin
            use_div = le;
            direct  = f_ff;
            num_sel = {32'd0, bsq_ff, 1'b0};
            den_in  = {32'd0, ssum};
         end
         default: begin
            use_div = le;
            direct  = f_ff;
            num_sel = num;
            den_in  = {1'b0, bsq_ff} + {1'b0, fsq_ff};
         end
      endcase
   end

   // one restoring step; quotient always fits 32 bits so the top half seeds rem
   assign trial = {rem_ff, nlo_ff[31]};
   assign tsub  = trial - {1'b0, den_ff};
   assign mag_neg = 33'd0 - {1'b0, mag_ff};

   always_comb begin
      st_in  = st_ff;
      mag_in = mag_ff;
      rem_in = rem_ff;
      nlo_in = nlo_ff;
      cnt_in = cnt_ff;
      ov_in  = ov_ff && !out_ready;
      osl_in = osl_ff;
      unique case (st_ff)
         ST_IDLE: if (!q_empty) st_in = job.zero ? ST_OUT : ST_SQB;
         ST_SQB:  st_in = ST_SQF;
         ST_SQF:  st_in = ST_ML0;
         ST_ML0:  st_in = ST_ML1;
         ST_ML1:  st_in = ST_PREP;
         ST_PREP: begin
            if (use_div) begin
               rem_in = num_sel[96:32];
               nlo_in = num_sel[31:0];
               cnt_in = 5'd31;
               st_in  = ST_DIV;
            end else begin
               mag_in = direct;
               st_in  = ST_OUT;
            end
         end
         ST_DIV: begin
            if (!tsub[65]) rem_in = tsub[64:0];
            else rem_in = trial[64:0];
            mag_in = {mag_ff[30:0], !tsub[65]};
            nlo_in = {nlo_ff[30:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) st_in = ST_OUT;
         end
         ST_OUT: begin
            if (!ov_ff || out_ready) begin
               ov_in  = 1'b1;
               osl_in = neg_ff ? mag_neg : {1'b0, mag_ff};
               st_in  = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (pop) mag_in = '0;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_ff   <= job.bmag;
         f_ff   <= job.fmag;
         neg_ff <= job.neg;
      end
      if (st_ff == ST_SQB) bsq_ff <= prod[63:0];
      if (st_ff == ST_SQF) fsq_ff <= prod[63:0];
      if (st_ff == ST_ML0) p0_ff <= prod[64:0];
      if (st_ff == ST_ML1) p1_ff <= prod[64:0];
      if (st_ff == ST_PREP) den_ff <= den_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      nlo_ff <= nlo_in;
      cnt_ff <= cnt_in;
      osl_ff <= osl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
      end
   end
endmodule

// File: hw/rtl/tvd_slope_limiter.sv
// Top level of the TVD slope limiter.
// Usage:
//   req_* takes one signed Q16.16 cell value per word (tdata) with a row-start
//   flag in tuser. Once two cells of a row are held, each further cell yields
//   one limited slope for the middle cell on rsp_*; the first two cells of a
//   row yield nothing.
//   csr_we/csr_wdata set the limiter mode (superbee, minbee, van Leer,
//   van Albada); write it only while the block is idle.
// Timing:
//   The front end accepts words while the two-entry job queue is not full.
//   The back end takes zero or opposite-sign windows straight to output; other
//   windows pass the shared multiplier (states SQB, SQF, ML0, ML1) and a setup
//   state, then go to output directly or through 32 radix-2 divider steps.
//   The back end takes no new job from the queue until the last is output.
// Reset:
//   Synchronous, active high: clears the window, the queue, the mode and the
//   output valid.
// Stall:
//   A result waits in the output register while rsp_tready is low; the back
//   end finishes its next job and the queue fills, then req_tready drops.
module tvd_slope_limiter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] cell_value
   input  logic        req_tuser,   // [0] row_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [32:0] limited_slope, [39:33] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata    // [1:0] limiter_mode
);
   tvd_pkg::mode_type mode_ff;
   tvd_pkg::job_type  push_job, pop_job;
   logic push, pop, q_full, q_empty;
   logic [tvd_pkg::SLOPE_W-1:0] slope;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= tvd_pkg::MODE_SUPERBEE;
      else if (csr_we) mode_ff <= tvd_pkg::mode_type'(csr_wdata);
   end

   tvd_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .cell_value(req_tdata), .row_start(req_tuser),
      .push(push), .job(push_job), .q_full(q_full)
   );

   tvd_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .wdata(push_job), .full(q_full),
      .pop(pop), .empty(q_empty), .rdata(pop_job)
   );

   tvd_back u_back (
      .clock(clock), .reset(reset), .mode(mode_ff),
      .q_empty(q_empty), .job(pop_job), .pop(pop),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_slope(slope)
   );

   assign rsp_tdata = {7'd0, slope};
endmodule

// File: sim/tb.sv
// Self-checking testbench for the TVD slope limiter: predicts each slope and checks the stream.
module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_wdata = '0;

   localparam int WATCHDOG_LIMIT = 20000;

   tvd_slope_limiter uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // predictor state
   tvd_pkg::mode_type  mode_shadow;
   logic signed [32:0] win_prev, win_mid;
   int                 win_count;
   logic [32:0]        slope_queue[$];

   int errors = 0;
   int words_sent = 0;
   int slopes_seen = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit [3:0] modes_used = '0;

   function automatic logic [63:0] limit_mag(tvd_pkg::mode_type m, logic [63:0] bm,
                                             logic [63:0] fm);
      logic [127:0] num, den;
      logic [63:0]  bsq;
      bsq = bm * bm;
      case (m)
         tvd_pkg::MODE_SUPERBEE: begin
            if (2 * bm <= fm) return 64'(128'(bsq) * 2 / fm);
            return (bm <= fm) ? bm : fm;
         end
         tvd_pkg::MODE_MINBEE: begin
            if (2 * bm <= fm) return bsq / fm;
            return (bm <= fm) ? bm : fm;
         end
         tvd_pkg::MODE_VANLEER: begin
            if (bm <= fm) return 64'(128'(bsq) * 2 / (bm + fm));
            return fm;
         end
         default: begin
            if (bm > fm) return fm;
            num = 128'(bsq) * 128'(bm + fm);
            den = 128'(bsq) + 128'(fm * fm);
            return 64'(num / den);
         end
      endcase
   endfunction

   task automatic predict_word(logic [31:0] cell_word, logic rs);
      logic signed [32:0] nxt, b, f;
      logic [63:0] bm, fm, mag;
      nxt = 33'(signed'(cell_word));
      if (rs) win_count = 0;
      if (win_count >= 2) begin
         b = win_mid - win_prev;
         f = nxt - win_mid;
         mag = '0;
         if (b != 0 && f != 0 && (b[32] == f[32])) begin
            bm = b[32] ? 64'(-b) : 64'(b);
            fm = f[32] ? 64'(-f) : 64'(f);
            mag = limit_mag(mode_shadow, bm, fm);
         end
         slope_queue.push_back(b[32] ? 33'(-mag) : 33'(mag));
      end else begin
         win_count++;
      end
      win_prev = win_mid;
      win_mid = nxt;
   endtask

   // valid stays up after acceptance until the next word or an idle cycle replaces it
   task automatic send_word(logic [31:0] cell_word, logic rs);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= cell_word;
      req_tuser <= rs;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(cell_word, rs);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic drain_wait();
      req_tvalid <= 1'b0;
      while (slope_queue.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic set_mode(tvd_pkg::mode_type m);
      drain_wait();
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we <= 1'b0;
      mode_shadow = m;
      modes_used[m] = 1'b1;
   endtask

   // receiver: random backpressure plus checking against the oldest expectation
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      logic [32:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         slopes_seen++;
         if (slope_queue.size() == 0) begin
            $display("%0t: unexpected slope, expected none actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = slope_queue.pop_front();
            if (rsp_tdata[32:0] !== want || rsp_tdata[39:33] !== 7'd0) begin
               $display("%0t: slope mismatch, expected %h actual %h", $time, want, rsp_tdata);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no accepted word on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] rand_cell();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000);
         2: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(50)
                                     : 32'h8000_0000 + $urandom_range(50);
         default: return 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
      endcase
   endfunction

   task automatic test_directed();
      // row of extremes: full-scale swings, flat run, sign changes
      send_word(32'h0000_0000, 1'b1);
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'h8000_0000, 1'b0);  // opposite signs
      send_word(32'h8000_0000, 1'b0);  // zero forward difference
      send_word(32'h7FFF_FFFF, 1'b0);  // zero backward difference
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h0001_0000, 1'b1);  // row start mid-stream
      send_word(32'h0002_0000, 1'b0);
      send_word(32'h0002_8000, 1'b0);  // 2B > F
      send_word(32'h0006_8000, 1'b0);  // 2B <= F
      send_word(32'h0007_0000, 1'b0);  // B > F
      send_word(32'h0007_0000, 1'b1);
      send_word(32'h0006_0000, 1'b0);
      send_word(32'h0004_0000, 1'b0);  // falling, negative slope
      send_word(32'h0000_0000, 1'b0);
   endtask

   task automatic test_random_rows(int count);
      int i;
      logic [31:0] c;
      i = 0;
      while (i < count) begin
         // mostly smooth rows, occasional noise
         c = rand_cell();
         send_word(c, 1'b1);
         i++;
         repeat ($urandom_range(12, 2)) begin
            if ($urandom_range(9) == 0) c = rand_cell();
            else c = c + 32'($signed($urandom_range(4096)) - 2048) * $urandom_range(64);
            send_word(c, $urandom_range(40) == 0);
            i++;
         end
      end
   endtask

   task automatic test_modes(int per_mode);
      tvd_pkg::mode_type m;
      for (int k = 0; k < 4; k++) begin
         m = tvd_pkg::mode_type'(k);
         set_mode(m);
         test_directed();
         test_random_rows(per_mode);
      end
   endtask

   initial begin
      mode_shadow = tvd_pkg::MODE_SUPERBEE;
      win_prev = '0;
      win_mid = '0;
      win_count = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 27; recv_idle_pct = 83;
      test_modes(140);
      // sender holds off until everything has drained
      drain_wait();
      send_idle_pct = 83; recv_idle_pct = 27;
      test_modes(140);
      send_idle_pct = 0; recv_idle_pct = 0;
      set_mode(tvd_pkg::MODE_VANALBADA);
      test_random_rows(40);
      test_modes(105);

      drain_wait();
      $display("Sent %0d cell words, checked %0d slopes, limiter modes seen %b.",
               words_sent, slopes_seen, modes_used);
      if (errors == 0 && slope_queue.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

// File: filelist.f
hw/rtl/tvd_pkg.sv
hw/rtl/tvd_front.sv
hw/rtl/tvd_fifo.sv
hw/rtl/tvd_back.sv
hw/rtl/tvd_slope_limiter.sv
sim/tb.sv
